### rtl/rpc_pkg.sv
package rpc_pkg;

  localparam logic [2:0] MODE_THRESH  = 3'd0;
  localparam logic [2:0] MODE_GRAY    = 3'd1;
  localparam logic [2:0] MODE_ISOLATE = 3'd2;
  localparam logic [2:0] MODE_REMOVE  = 3'd3;
  localparam logic [2:0] MODE_SEPIA   = 3'd4;

  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  localparam logic [1:0] REG_MODE     = 2'd0;
  localparam logic [1:0] REG_CHANNEL  = 2'd1;
  localparam logic [1:0] REG_IN_MAX   = 2'd2;
  localparam logic [1:0] REG_GRAY_MAX = 2'd3;

  // floor(x/3) = (x * DIV3_MUL) >> DIV3_SHIFT for x below 2^18
  localparam logic [17:0] DIV3_MUL   = 18'd174763;
  localparam int          DIV3_SHIFT = 19;
  // floor(x/1000) = (x * DIV1K_MUL) >> DIV1K_SHIFT for x below 256000
  localparam logic [18:0] DIV1K_MUL   = 19'd268436;
  localparam int          DIV1K_SHIFT = 28;
  localparam logic [26:0] SEPIA_LIMIT = 27'd256000;
  localparam logic [7:0]  SEPIA_CLAMP = 8'd255;

  localparam logic [10:0] SEPIA_COEF [3][3] = '{
    '{11'd393, 11'd769, 11'd189},
    '{11'd349, 11'd686, 11'd168},
    '{11'd272, 11'd534, 11'd131}
  };

  typedef struct packed {
    logic        valid;
    logic [15:0] rem;
    logic [15:0] dlo;
    logic [15:0] quo;
    logic        sat;
    logic        bit_o;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
  } div_t;

endpackage

### rtl/rpc_div_step.sv
module rpc_div_step (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic [15:0]   input_max,
  input  rpc_pkg::div_t d_in,
  output rpc_pkg::div_t d_out
);
  import rpc_pkg::*;

  logic [16:0] trial;
  logic [16:0] diff;
  logic        ge;
  div_t        d_next;

  always_comb begin
    trial = {d_in.rem, d_in.dlo[15]};
    diff  = trial - {1'b0, input_max};
    ge    = trial >= {1'b0, input_max};
    d_next = d_in;
    d_next.rem = ge ? diff[15:0] : trial[15:0];
    d_next.dlo = {d_in.dlo[14:0], 1'b0};
    d_next.quo = {d_in.quo[14:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_out.valid <= 1'b0;
    end else if (en) begin
      d_out.valid <= d_next.valid;
    end
    if (en) begin
      d_out.rem   <= d_next.rem;
      d_out.dlo   <= d_next.dlo;
      d_out.quo   <= d_next.quo;
      d_out.sat   <= d_next.sat;
      d_out.bit_o <= d_next.bit_o;
      d_out.red   <= d_next.red;
      d_out.green <= d_next.green;
      d_out.blue  <= d_next.blue;
    end
  end

endmodule

### rtl/rpc_front.sv
module rpc_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [15:0]   red,
  input  logic [15:0]   green,
  input  logic [15:0]   blue,
  input  logic [2:0]    conv_mode,
  input  logic [1:0]    channel_select,
  input  logic [15:0]   input_max,
  input  logic [15:0]   gray_max,
  output rpc_pkg::div_t d_out
);
  import rpc_pkg::*;

  // stage 1
  logic        v1;
  logic [15:0] px1 [3];
  logic [17:0] sum1;
  // stage 2
  logic        v2;
  logic [35:0] avg_prod2;
  logic [26:0] sep2 [3];
  logic        bit2;
  logic [15:0] res2 [3];
  // stage 3
  logic        v3;
  logic [15:0] avg3;
  logic        sep_big3 [3];
  logic [37:0] sep_prod3 [3];
  logic        bit3;
  logic [15:0] res3 [3];

  logic [1:0]  ch;
  logic        bit_c;
  logic [15:0] res_c [3];
  logic [26:0] sep_c [3];
  logic [31:0] gprod;
  logic [15:0] fin_c [3];
  div_t        d_next;

  always_comb begin
    ch = (channel_select == 2'd3) ? CH_BLUE : channel_select;
    bit_c = 1'b0;
    for (int i = 0; i < 3; i++) begin
      res_c[i] = '0;
      sep_c[i] = 27'(px1[0]) * 27'(SEPIA_COEF[i][0])
               + 27'(px1[1]) * 27'(SEPIA_COEF[i][1])
               + 27'(px1[2]) * 27'(SEPIA_COEF[i][2]);
    end
    case (conv_mode)
      MODE_THRESH: bit_c = {sum1, 1'b0} < ({3'b000, input_max} + {2'b00, input_max, 1'b0});
      MODE_ISOLATE: res_c[ch] = px1[ch];
      MODE_REMOVE: begin
        for (int i = 0; i < 3; i++) begin
          res_c[i] = (2'(i) == ch) ? 16'd0 : px1[i];
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    gprod = avg3 * gray_max;
    for (int i = 0; i < 3; i++) begin
      fin_c[i] = res3[i];
      if (conv_mode == MODE_SEPIA) begin
        fin_c[i] = sep_big3[i] ? {8'd0, SEPIA_CLAMP}
                               : {8'd0, sep_prod3[i][DIV1K_SHIFT +: 8]};
      end
    end
    d_next.valid = v3;
    d_next.rem   = gprod[31:16];
    d_next.dlo   = gprod[15:0];
    d_next.quo   = '0;
    d_next.sat   = avg3 >= input_max;
    d_next.bit_o = bit3;
    d_next.red   = fin_c[0];
    d_next.green = fin_c[1];
    d_next.blue  = fin_c[2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      d_out.valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      d_out.valid <= d_next.valid;
    end
    if (en) begin
      d_out.rem   <= d_next.rem;
      d_out.dlo   <= d_next.dlo;
      d_out.quo   <= d_next.quo;
      d_out.sat   <= d_next.sat;
      d_out.bit_o <= d_next.bit_o;
      d_out.red   <= d_next.red;
      d_out.green <= d_next.green;
      d_out.blue  <= d_next.blue;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px1[0] <= red;
      px1[1] <= green;
      px1[2] <= blue;
      sum1 <= {2'b00, red} + {2'b00, green} + {2'b00, blue};

      avg_prod2 <= sum1 * DIV3_MUL;
      bit2 <= bit_c;
      for (int i = 0; i < 3; i++) begin
        sep2[i] <= sep_c[i];
        res2[i] <= res_c[i];
      end

      avg3 <= avg_prod2[DIV3_SHIFT +: 16];
      bit3 <= bit2;
      for (int i = 0; i < 3; i++) begin
        sep_big3[i]  <= sep2[i] >= SEPIA_LIMIT;
        sep_prod3[i] <= 38'(sep2[i][17:0]) * 38'(DIV1K_MUL);
        res3[i]      <= res2[i];
      end
    end
  end

endmodule

### rtl/rgb_pixel_color_converter.sv
// RGB pixel colour converter: one pixel is taken per cycle and one result
// leaves for each pixel, after four arithmetic stages and then a 16-stage
// restoring divider for the grayscale rescale by input_max, one quotient
// bit a stage. The whole pipeline advances together;
// a stalled result holds every stage, so in_stall follows out_stall while
// out_valid is high. Configuration registers must be written only when no
// pixel is in flight; the mode is read live, not carried with each pixel.
module rgb_pixel_color_converter #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [1:0]             cfg_index,
  input  logic [15:0]            cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [SAMPLE_BITS-1:0] red_in,
  input  logic [SAMPLE_BITS-1:0] green_in,
  input  logic [SAMPLE_BITS-1:0] blue_in,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   bit_out,
  output logic [15:0]            gray_out,
  output logic [SAMPLE_BITS-1:0] red_out,
  output logic [SAMPLE_BITS-1:0] green_out,
  output logic [SAMPLE_BITS-1:0] blue_out
);
  import rpc_pkg::*;

  localparam int DIV_STEPS = 16;

  logic [2:0]  conv_mode;
  logic [1:0]  channel_select;
  logic [15:0] input_max;
  logic [15:0] gray_max;
  logic        en;
  div_t        chain [DIV_STEPS+1];
  div_t        last;

  always_ff @(posedge clk) begin
    if (rst) begin
      conv_mode      <= MODE_THRESH;
      channel_select <= CH_BLUE;
      input_max      <= 16'd255;
      gray_max       <= 16'd255;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_MODE:     conv_mode      <= cfg_data[2:0];
        REG_CHANNEL:  channel_select <= cfg_data[1:0];
        REG_IN_MAX:   input_max      <= cfg_data;
        REG_GRAY_MAX: gray_max       <= cfg_data;
        default: ;
      endcase
    end
  end

  // hold the whole pipeline while a result waits
  assign en       = !(last.valid && out_stall);
  assign in_stall = !en;

  rpc_front u_front (
    .clk            (clk),
    .rst            (rst),
    .en             (en),
    .in_valid       (in_valid),
    .red            (16'(red_in)),
    .green          (16'(green_in)),
    .blue           (16'(blue_in)),
    .conv_mode      (conv_mode),
    .channel_select (channel_select),
    .input_max      (input_max),
    .gray_max       (gray_max),
    .d_out          (chain[0])
  );

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    rpc_div_step u_step (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .input_max (input_max),
      .d_in      (chain[k]),
      .d_out     (chain[k+1])
    );
  end

  assign last      = chain[DIV_STEPS];
  assign out_valid = last.valid;
  assign bit_out   = last.bit_o;
  assign gray_out  = (conv_mode != MODE_GRAY) ? 16'd0 :
                     (last.sat ? gray_max : last.quo);
  assign red_out   = last.red[SAMPLE_BITS-1:0];
  assign green_out = last.green[SAMPLE_BITS-1:0];
  assign blue_out  = last.blue[SAMPLE_BITS-1:0];

endmodule
